// ----- rtl/arp_pkg.sv -----
// Shared types, constants and helpers for the arpeggiator note selector.
// Used by arp_ctrl, arp_dp and arpeggiator_note_selector; depends on nothing.
package arp_pkg;

  // Key table size and derived widths.
  localparam int SLOTS       = 16;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int MAX_OCTAVES = 4;
  localparam int SEMITONES   = 12;

  // Input word kinds.
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_PRESS   = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  // Pattern modes.
  localparam logic [2:0] PAT_UP      = 3'd0;
  localparam logic [2:0] PAT_DOWN    = 3'd1;
  localparam logic [2:0] PAT_UPDOWN  = 3'd2;
  localparam logic [2:0] PAT_DOWNUP  = 3'd3;
  localparam logic [2:0] PAT_RANDOM  = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PATTERN = 3'd0;
  localparam logic [2:0] CFG_SPAN    = 3'd1;
  localparam logic [2:0] CFG_DUPS    = 3'd2;
  localparam logic [2:0] CFG_EDGES   = 3'd3;
  localparam logic [2:0] CFG_HOLD    = 3'd4;
  localparam logic [2:0] CFG_LATCH   = 3'd5;
  localparam logic [2:0] CFG_SYNC    = 3'd6;

  typedef struct packed {
    logic [2:0] pattern_mode;
    logic [2:0] octave_span;
    logic       allow_duplicates;
    logic       repeat_ends;
    logic       hold_mode;
    logic       latch_sustain;
    logic       keyboard_sync;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             key_press;
    logic             key_release;
    logic             tick_load;
    logic             prep;
    logic             scan;
    logic             sel;
    logic             div;
    logic             pick;
    logic             fin;
    logic [CNT_W-1:0] idx;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic beat;
    logic rnd_empty;
    logic out_busy;
  } ctrl_sts_t;

  // Semitone offset of an octave number.
  function automatic logic [7:0] oct_ofs(input logic [2:0] o);
    return {5'd0, o} * 8'(SEMITONES);
  endfunction

endpackage

// ----- rtl/arp_ctrl.sv -----
// Controller state machine of the arpeggiator note selector.
// Sequences tick handling over the datapath; depends on arp_pkg.
module arp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        in_cmd,
  input  arp_pkg::cfg_t     cfg,
  input  arp_pkg::ctrl_sts_t sts,
  output arp_pkg::ctrl_cmd_t cmd
);
  import arp_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_SEL  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_PICK = 3'd5;
  localparam logic [2:0] ST_RD   = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Next state and step counter.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_cmd == CMD_TICK) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cnt_nxt   = '0;
        state_nxt = sts.beat ? ST_SCAN : ST_FIN;
      end
      ST_SCAN: begin
        if (cnt_r == CNT_W'(SLOTS)) state_nxt = ST_SEL;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_SEL: begin
        cnt_nxt = '0;
        if (cfg.pattern_mode == PAT_RANDOM && !sts.rnd_empty) state_nxt = ST_DIV;
        else state_nxt = ST_RD;
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(15)) begin
          state_nxt = ST_PICK;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_PICK: begin
        if (cnt_r == CNT_W'(SLOTS - 1)) state_nxt = ST_RD;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_RD: state_nxt = ST_FIN;
      ST_FIN: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Command decode.
  always_comb begin
    cmd             = '0;
    cmd.key_press   = accept && in_cmd == CMD_PRESS;
    cmd.key_release = accept && in_cmd == CMD_RELEASE;
    cmd.tick_load   = accept && in_cmd == CMD_TICK;
    cmd.prep        = (state_r == ST_PREP);
    cmd.scan        = (state_r == ST_SCAN);
    cmd.sel         = (state_r == ST_SEL);
    cmd.div         = (state_r == ST_DIV);
    cmd.pick        = (state_r == ST_PICK);
    cmd.fin         = (state_r == ST_FIN) && !sts.out_busy;
    cmd.idx         = cnt_r;
  end

  scan_bound_a: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> cnt_r <= CNT_W'(SLOTS))
    else $error("scan counter ran past the table");
  scan_exit_a: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && cnt_r == CNT_W'(SLOTS)) |=> state_r == ST_SEL)
    else $error("scan did not hand over to selection");
  fin_exit_a: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> state_r == ST_IDLE)
    else $error("result load did not return to idle");

endmodule

// ----- rtl/arp_dp.sv -----
// Datapath of the arpeggiator note selector: key table, scan accumulators,
// remainder unit, random pick and result register. Depends on arp_pkg.
module arp_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  arp_pkg::cfg_t      cfg,
  input  arp_pkg::ctrl_cmd_t cmd,
  output arp_pkg::ctrl_sts_t sts,
  input  logic               in_beat,
  input  logic               in_pedal,
  input  logic [3:0]         in_slot,
  input  logic [6:0]         in_key,
  input  logic [6:0]         in_velocity,
  input  logic [15:0]        in_rand_pick,
  input  logic [15:0]        in_rand_octave,
  input  logic               out_tready,
  output logic               out_tvalid,
  output logic               out_off_valid,
  output logic [7:0]         out_off_note,
  output logic               out_on_valid,
  output logic [7:0]         out_on_note,
  output logic [6:0]         out_on_velocity,
  output logic               out_sync_restart
);
  import arp_pkg::*;

  // Key table storage.
  logic [6:0]        mem_note [SLOTS];
  logic [6:0]        mem_vel  [SLOTS];
  logic [6:0]        rd_note_r, rd_vel_r;
  logic [SLOT_W-1:0] rd_addr;
  logic [SLOTS-1:0]  valid_r, pressed_r;

  // Arpeggiator state.
  logic [7:0]        cur_note_r;
  logic [SLOT_W-1:0] cur_slot_r;
  logic              half_r, half_nxt;
  logic              restart_r;

  // Latched tick word.
  logic              beat_r, pedal_r, sync_r;
  logic [15:0]       rpick_r, roct_r;

  // Scan accumulators.
  logic              up_f_r, dn_f_r, lo_f_r, hi_f_r;
  logic [7:0]        up_n_r, dn_n_r, hi_n_r;
  logic [6:0]        lo_n_r;
  logic [SLOT_W-1:0] up_i_r, dn_i_r, lo_i_r, hi_i_r;
  logic [CNT_W-1:0]  vcnt_r;

  // Selection and random pick.
  logic              sel_f_r, sel_f_nxt;
  logic [SLOT_W-1:0] sel_i_r, sel_i_nxt;
  logic [7:0]        sel_n_r, sel_n_nxt;
  logic [CNT_W-1:0]  prem_r, seen_r;
  logic [1:0]        orem_r;

  // Output register.
  logic              out_valid_r;
  logic              off_valid_r, on_valid_r, sync_out_r;
  logic [7:0]        off_note_r, on_note_r;
  logic [6:0]        on_vel_r;

  logic [2:0]        octs;
  logic [SLOT_W-1:0] p_idx;
  logic              p_live;
  logic              up_hit, dn_hit;
  logic [7:0]        up_val, dn_val, cand, hi_val;
  logic [SLOTS-1:0]  valid_clr;
  logic              restart_eff, any_pressed;
  logic              going_up;
  logic [CNT_W-1:0]  p_shift;
  logic [2:0]        o_shift;
  logic [7:0]        fin_note;
  logic              commit;

  // Octave span saturated to 1..MAX_OCTAVES.
  always_comb begin
    octs = cfg.octave_span;
    if (cfg.octave_span == 3'd0) octs = 3'd1;
    else if (cfg.octave_span > 3'(MAX_OCTAVES)) octs = 3'(MAX_OCTAVES);
  end

  assign any_pressed = |pressed_r;
  assign rd_addr     = cmd.scan ? cmd.idx[SLOT_W-1:0] : sel_i_r;
  assign p_idx       = SLOT_W'(cmd.idx - 1'b1);
  assign p_live      = cmd.scan && (cmd.idx != '0) && valid_r[p_idx];

  // Table memory: written on a press, read with a registered port.
  always_ff @(posedge clk) begin
    if (cmd.key_press && {1'b0, in_slot} < 5'(SLOTS)) begin
      mem_note[in_slot[SLOT_W-1:0]] <= in_key;
      mem_vel[in_slot[SLOT_W-1:0]]  <= in_velocity;
    end
    rd_note_r <= mem_note[rd_addr];
    rd_vel_r  <= mem_vel[rd_addr];
  end

  // Per-slot search candidates: nearest octave above and below the current note.
  always_comb begin
    up_hit = 1'b0;
    up_val = '0;
    dn_hit = 1'b0;
    dn_val = '0;
    cand   = '0;
    for (int o = 0; o < MAX_OCTAVES; o++) begin
      cand = {1'b0, rd_note_r} + oct_ofs(3'(o));
      if (!up_hit && 3'(o) < octs &&
          (cand > cur_note_r ||
           (cand == cur_note_r && cfg.allow_duplicates && p_idx > cur_slot_r))) begin
        up_hit = 1'b1;
        up_val = cand;
      end
    end
    for (int k = MAX_OCTAVES; k > 0; k--) begin
      cand = {1'b0, rd_note_r} + oct_ofs(3'(k - 1));
      if (!dn_hit && 3'(k - 1) < octs &&
          (cand < cur_note_r ||
           (cand == cur_note_r && cfg.allow_duplicates && p_idx > cur_slot_r))) begin
        dn_hit = 1'b1;
        dn_val = cand;
      end
    end
    hi_val = {1'b0, rd_note_r} + oct_ofs(octs - 3'd1);
  end

  // Sustain clear ahead of restart detection.
  always_comb begin
    valid_clr = valid_r;
    if (!cfg.hold_mode && cfg.latch_sustain && !pedal_r) valid_clr = valid_r & pressed_r;
    restart_eff = restart_r || (valid_clr == '0);
  end

  // Pattern decision from the accumulated scan.
  always_comb begin
    sel_f_nxt = 1'b0;
    sel_i_nxt = sel_i_r;
    sel_n_nxt = sel_n_r;
    half_nxt  = half_r;
    going_up  = (cfg.pattern_mode == PAT_UPDOWN) ? !half_r : half_r;
    case (cfg.pattern_mode)
      PAT_UP: begin
        if (restart_r || !up_f_r) begin
          sel_f_nxt = lo_f_r; sel_i_nxt = lo_i_r; sel_n_nxt = {1'b0, lo_n_r};
        end else begin
          sel_f_nxt = 1'b1; sel_i_nxt = up_i_r; sel_n_nxt = up_n_r;
        end
      end
      PAT_DOWN: begin
        if (restart_r || !dn_f_r) begin
          sel_f_nxt = hi_f_r; sel_i_nxt = hi_i_r; sel_n_nxt = hi_n_r;
        end else begin
          sel_f_nxt = 1'b1; sel_i_nxt = dn_i_r; sel_n_nxt = dn_n_r;
        end
      end
      PAT_UPDOWN, PAT_DOWNUP: begin
        if (going_up) begin
          if (!up_f_r || (!cfg.repeat_ends && hi_f_r && up_i_r == hi_i_r &&
                          up_n_r == hi_n_r)) begin
            sel_f_nxt = hi_f_r; sel_i_nxt = hi_i_r; sel_n_nxt = hi_n_r;
            half_nxt  = !half_r;
          end else begin
            sel_f_nxt = 1'b1; sel_i_nxt = up_i_r; sel_n_nxt = up_n_r;
          end
        end else begin
          if (!dn_f_r || (!cfg.repeat_ends && lo_f_r && dn_i_r == lo_i_r &&
                          dn_n_r == {1'b0, lo_n_r})) begin
            sel_f_nxt = lo_f_r; sel_i_nxt = lo_i_r; sel_n_nxt = {1'b0, lo_n_r};
            half_nxt  = !half_r;
          end else begin
            sel_f_nxt = 1'b1; sel_i_nxt = dn_i_r; sel_n_nxt = dn_n_r;
          end
        end
        if (restart_r) begin
          if (cfg.pattern_mode == PAT_UPDOWN) begin
            sel_f_nxt = lo_f_r; sel_i_nxt = lo_i_r; sel_n_nxt = {1'b0, lo_n_r};
          end else begin
            sel_f_nxt = hi_f_r; sel_i_nxt = hi_i_r; sel_n_nxt = hi_n_r;
          end
          half_nxt = 1'b0;
        end
      end
      default: sel_f_nxt = 1'b0;
    endcase
  end

  // One restoring remainder step per cycle for the random note and octave.
  assign p_shift = {prem_r[CNT_W-2:0], rpick_r[4'd15 - cmd.idx[3:0]]};
  assign o_shift = {orem_r, roct_r[4'd15 - cmd.idx[3:0]]};

  // Final note and commit condition.
  assign fin_note = (cfg.pattern_mode == PAT_RANDOM) ?
                    ({1'b0, rd_note_r} + oct_ofs({1'b0, orem_r})) : sel_n_r;
  assign commit   = cmd.fin && beat_r && sel_f_r;

  // Slot marks.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      pressed_r <= '0;
    end else if (cmd.key_press) begin
      if ({1'b0, in_slot} < 5'(SLOTS)) begin
        // A fresh press in hold mode drops the held notes first.
        valid_r <= ((cfg.hold_mode && !any_pressed) ? '0 : valid_r) |
                   (SLOTS'(1) << in_slot[SLOT_W-1:0]);
        pressed_r[in_slot[SLOT_W-1:0]] <= 1'b1;
      end
    end else if (cmd.key_release) begin
      if ({1'b0, in_slot} < 5'(SLOTS)) begin
        pressed_r[in_slot[SLOT_W-1:0]] <= 1'b0;
        if (!cfg.hold_mode && (!in_pedal || !cfg.latch_sustain))
          valid_r[in_slot[SLOT_W-1:0]] <= 1'b0;
      end
    end else if (cmd.prep) begin
      valid_r <= valid_clr;
    end else if (commit && !cfg.hold_mode && !(pedal_r || cfg.latch_sustain) &&
                 !any_pressed) begin
      valid_r <= '0;
    end
  end

  // Arpeggiator control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_note_r <= '0;
      cur_slot_r <= '0;
      half_r     <= 1'b0;
      restart_r  <= 1'b1;
      sync_r     <= 1'b0;
    end else if (cmd.prep) begin
      restart_r <= restart_eff;
      sync_r    <= restart_eff && cfg.keyboard_sync;
      if (restart_eff) half_r <= 1'b0;
    end else if (cmd.sel) begin
      half_r <= half_nxt;
    end else if (commit) begin
      cur_note_r <= fin_note;
      cur_slot_r <= sel_i_r;
      restart_r  <= 1'b0;
    end
  end

  // Tick word, accumulators, selection and remainders.
  always_ff @(posedge clk) begin
    if (cmd.tick_load) begin
      beat_r  <= in_beat;
      pedal_r <= in_pedal;
      rpick_r <= in_rand_pick;
      roct_r  <= in_rand_octave;
    end
    if (cmd.prep) begin
      up_f_r <= 1'b0;
      dn_f_r <= 1'b0;
      lo_f_r <= 1'b0;
      hi_f_r <= 1'b0;
      vcnt_r <= '0;
    end else if (p_live) begin
      if (up_hit && (!up_f_r || up_val < up_n_r)) begin
        up_f_r <= 1'b1; up_n_r <= up_val; up_i_r <= p_idx;
      end
      if (dn_hit && (!dn_f_r || dn_val > dn_n_r)) begin
        dn_f_r <= 1'b1; dn_n_r <= dn_val; dn_i_r <= p_idx;
      end
      if (!lo_f_r || {1'b0, rd_note_r} < {1'b0, lo_n_r} + 8'(cfg.allow_duplicates)) begin
        lo_f_r <= 1'b1; lo_n_r <= rd_note_r; lo_i_r <= p_idx;
      end
      if (!hi_f_r || {1'b0, hi_val} + 9'(cfg.allow_duplicates) > {1'b0, hi_n_r}) begin
        hi_f_r <= 1'b1; hi_n_r <= hi_val; hi_i_r <= p_idx;
      end
      vcnt_r <= vcnt_r + 1'b1;
    end
    if (cmd.sel) begin
      sel_f_r <= sel_f_nxt;
      sel_i_r <= sel_i_nxt;
      sel_n_r <= sel_n_nxt;
      prem_r  <= '0;
      orem_r  <= '0;
      seen_r  <= '0;
    end else if (cmd.div) begin
      prem_r <= (p_shift >= vcnt_r) ? p_shift - vcnt_r : p_shift;
      orem_r <= (o_shift >= octs) ? 2'(o_shift - octs) : o_shift[1:0];
    end else if (cmd.pick) begin
      if (valid_r[cmd.idx[SLOT_W-1:0]] && !sel_f_r) begin
        if (seen_r == prem_r) begin
          sel_f_r <= 1'b1;
          sel_i_r <= cmd.idx[SLOT_W-1:0];
        end else begin
          seen_r <= seen_r + 1'b1;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      off_valid_r <= beat_r;
      off_note_r  <= beat_r ? cur_note_r : 8'd0;
      on_valid_r  <= beat_r && sel_f_r;
      on_note_r   <= (beat_r && sel_f_r) ? fin_note : 8'd0;
      on_vel_r    <= (beat_r && sel_f_r) ? rd_vel_r : 7'd0;
      sync_out_r  <= sync_r;
    end
  end

  assign out_tvalid       = out_valid_r;
  assign out_off_valid    = off_valid_r;
  assign out_off_note     = off_note_r;
  assign out_on_valid     = on_valid_r;
  assign out_on_note      = on_note_r;
  assign out_on_velocity  = on_vel_r;
  assign out_sync_restart = sync_out_r;

  assign sts.beat      = beat_r;
  assign sts.rnd_empty = (vcnt_r == '0);
  assign sts.out_busy  = out_valid_r && !out_tready;

  on_needs_off_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (off_valid_r || !on_valid_r))
    else $error("note-on without a note-off");
  commit_clears_restart_a: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> !restart_r)
    else $error("restart still pending after a note-on");
  pick_valid_a: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pick && sel_f_r) |-> valid_r[sel_i_r])
    else $error("random pick landed on an empty slot");

endmodule

// ----- rtl/arpeggiator_note_selector.sv -----
// Arpeggiator note selector: top level with configuration registers.
// A press or release gives no word; a tick gives one result word, off the beat without
// a table scan, and on a beat after the slot scan over the table memory and, for a
// random beat, the 16-step remainder.
// One item is in work at a time; the next is taken while the result word waits.
// Reset (synchronous, rst_n low) clears slot marks, note state and registers.
module arpeggiator_note_selector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata: beat, pedal, slot[3:0], key[6:0], velocity[6:0], rand_pick[15:0],
  // rand_octave[15:0], then zero fill
  input  logic [55:0] in_tdata,
  // in_tuser: cmd[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: off_valid, off_note[7:0], on_valid, on_note[7:0], on_velocity[6:0],
  // sync_restart, then zero fill
  output logic [31:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [2:0]  cfg_wdata
);
  import arp_pkg::*;

  cfg_t      cfg_r;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  logic       off_valid, on_valid, sync_restart;
  logic [7:0] off_note, on_note;
  logic [6:0] on_velocity;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= cfg_t'{PAT_UP, 3'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PATTERN: cfg_r.pattern_mode     <= cfg_wdata;
        CFG_SPAN:    cfg_r.octave_span      <= cfg_wdata;
        CFG_DUPS:    cfg_r.allow_duplicates <= cfg_wdata[0];
        CFG_EDGES:   cfg_r.repeat_ends      <= cfg_wdata[0];
        CFG_HOLD:    cfg_r.hold_mode        <= cfg_wdata[0];
        CFG_LATCH:   cfg_r.latch_sustain    <= cfg_wdata[0];
        CFG_SYNC:    cfg_r.keyboard_sync    <= cfg_wdata[0];
        default:     ;
      endcase
    end
  end

  arp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .cfg       (cfg_r),
    .sts       (sts),
    .cmd       (cmd)
  );

  arp_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .sts              (sts),
    .in_beat          (in_tdata[0]),
    .in_pedal         (in_tdata[1]),
    .in_slot          (in_tdata[5:2]),
    .in_key           (in_tdata[12:6]),
    .in_velocity      (in_tdata[19:13]),
    .in_rand_pick     (in_tdata[35:20]),
    .in_rand_octave   (in_tdata[51:36]),
    .out_tready       (out_tready),
    .out_tvalid       (out_tvalid),
    .out_off_valid    (off_valid),
    .out_off_note     (off_note),
    .out_on_valid     (on_valid),
    .out_on_note      (on_note),
    .out_on_velocity  (on_velocity),
    .out_sync_restart (sync_restart)
  );

  // Result word packing.
  assign out_tdata = {6'd0, sync_restart, on_velocity, on_note, on_valid, off_note, off_valid};

endmodule
